/* rtl/plid_pkg.sv */
// ----------------------------------------------------------------------------
// plid_pkg
// Shared types and constants for the positional list core.
// ----------------------------------------------------------------------------
package plid_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int POS_W        = 6;
    localparam int WORD_W       = 32;
    localparam int LEN_W        = 6;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_GET    = 2'd2
    } func_t;

    // Broadcast to every cell: the operation that commits this cycle
    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctrl_t;

endpackage

/* rtl/plid_cell.sv */
// ----------------------------------------------------------------------------
// plid_cell
// One list slot: holds a word and shifts to or from its neighbors.
// ----------------------------------------------------------------------------
module plid_cell #(
    parameter int CAPACITY = plid_pkg::CAPACITY_DEF,
    parameter int INDEX    = 0
) (
    input  logic                              aclk,
    input  plid_pkg::cell_ctrl_t              ctrl,
    input  logic [$clog2(CAPACITY)-1:0]       sel_idx,
    input  logic signed [plid_pkg::WORD_W-1:0] ins_word,
    input  logic signed [plid_pkg::WORD_W-1:0] left_word,
    input  logic signed [plid_pkg::WORD_W-1:0] right_word,
    output logic signed [plid_pkg::WORD_W-1:0] data
);
    import plid_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.ins) begin
            // open a gap at the insert slot: later slots take from the left
            if (MY_IDX > sel_idx) begin
                data_next = left_word;
            end else if (MY_IDX == sel_idx) begin
                data_next = ins_word;
            end
        end else if (ctrl.del) begin
            // close the gap: this and later slots take from the right
            if (MY_IDX >= sel_idx) begin
                data_next = right_word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* rtl/positional_list_insert_delete_core.sv */
// ----------------------------------------------------------------------------
// positional_list_insert_delete_core
// Fixed-capacity ordered list of signed words with insert, delete and get.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready) carries one word per operation: s_func
//   selects insert, delete or get, s_position is the 1-based list position
//   and s_value is the word to insert. Result channel (m_valid/m_ready)
//   returns one word per operation: m_ok, m_read_value (entry for a
//   successful get, else 0) and m_list_length after the operation.
//   The list lives in a row of CAPACITY cells. An insert or delete shifts
//   all later cells by one at once; the result is registered and shows in
//   the cycle after acceptance, and a new word is accepted every cycle
//   while the receiver keeps up.
//   s_ready is high when the result register is empty or being drained, so
//   a stalled receiver holds the result and back-pressures the input after
//   one word. Reset (aresetn low, synchronous) empties the list and drops
//   any pending result; cell contents are not cleared, since slots beyond
//   the length are never read.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_core #(
    parameter int CAPACITY = plid_pkg::CAPACITY_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_func,
    input  logic [plid_pkg::POS_W-1:0]         s_position,
    input  logic signed [plid_pkg::WORD_W-1:0] s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_ok,
    output logic signed [plid_pkg::WORD_W-1:0] m_read_value,
    output logic [plid_pkg::LEN_W-1:0]         m_list_length
);
    import plid_pkg::*;

    localparam int IW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

    // list length
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // result register
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic                     ok_reg;
    logic                     ok_next;
    logic signed [WORD_W-1:0] read_reg;
    logic signed [WORD_W-1:0] read_next;
    logic [LEN_W-1:0]         len_reg;
    logic [LEN_W-1:0]         len_next;

    logic             accept;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] idx_full;
    logic [IW-1:0]    sel_idx;
    logic             pos_nz;
    logic             ins_ok;
    logic             in_range;
    cell_ctrl_t       ctrl;
    logic             op_ok;

    logic signed [WORD_W-1:0] cell_data [CAPACITY];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Range checks against the current length
    assign pos_ext  = CMP_W'(s_position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign idx_full = pos_ext - CMP_W'(1);
    assign sel_idx  = idx_full[IW-1:0];
    assign pos_nz   = (pos_ext != '0);
    assign in_range = pos_nz && (pos_ext <= cnt_ext);
    assign ins_ok   = pos_nz && (pos_ext <= cnt_ext + CMP_W'(1))
                      && (count_reg < CW'(CAPACITY));

    always_comb begin
        ctrl       = '0;
        op_ok      = 1'b0;
        count_next = count_reg;
        read_next  = '0;
        case (func_t'(s_func))
            FUNC_INSERT: begin
                op_ok    = ins_ok;
                ctrl.ins = accept && ins_ok;
                if (ins_ok) begin
                    count_next = count_reg + CW'(1);
                end
            end
            FUNC_DELETE: begin
                op_ok    = in_range;
                ctrl.del = accept && in_range;
                if (in_range) begin
                    count_next = count_reg - CW'(1);
                end
            end
            FUNC_GET: begin
                op_ok = in_range;
                if (in_range) begin
                    read_next = cell_data[sel_idx];
                end
            end
            default: begin
                op_ok = 1'b0;
            end
        endcase
    end

    // Result register: load on accept, drop when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        ok_next      = ok_reg;
        len_next     = len_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            ok_next      = op_ok;
            len_next     = LEN_W'(count_next);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ok_reg  <= ok_next;
        len_reg <= len_next;
        if (accept) begin
            read_reg <= read_next;
        end
    end

    // Row of cells: each slot sees its left and right neighbor
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [WORD_W-1:0] left_word;
        logic signed [WORD_W-1:0] right_word;

        if (i == 0) begin : g_first
            assign left_word = s_value;
        end else begin : g_mid_l
            assign left_word = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_word = cell_data[i];
        end else begin : g_mid_r
            assign right_word = cell_data[i+1];
        end

        plid_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .sel_idx    (sel_idx),
            .ins_word   (s_value),
            .left_word  (left_word),
            .right_word (right_word),
            .data       (cell_data[i])
        );
    end

    assign m_valid       = m_valid_reg;
    assign m_ok          = ok_reg;
    assign m_read_value  = read_reg;
    assign m_list_length = len_reg;

endmodule
